/* sv/prf_pkg.sv */
// Shared types and constants of the paged register file.
package prf_pkg;

  localparam int PAGE_COUNT  = 8;
  localparam int PAGE_W      = $clog2(PAGE_COUNT);
  localparam int REG_W       = 8;
  localparam int DATA_W      = 8;
  localparam int ADDR_W      = PAGE_W + REG_W;
  localparam int STORE_DEPTH = PAGE_COUNT << REG_W;
  localparam int CFG_INDEX_W = 8;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_WRITE_START = 2'd0;
  localparam logic [1:0] REQ_READ_START  = 2'd1;
  localparam logic [1:0] REQ_WRITE_BYTE  = 2'd2;
  localparam logic [1:0] REQ_READ_BYTE   = 2'd3;

  // Special register offsets and their reset contents.
  localparam logic [REG_W-1:0]  PAGE_REG       = 8'hFF;
  localparam logic [REG_W-1:0]  CHIP_ID_REG    = 8'hF4;
  localparam logic [REG_W-1:0]  REVISION_REG   = 8'hF5;
  localparam logic [DATA_W-1:0] CHIP_ID_RESET  = 8'h86;
  localparam logic [DATA_W-1:0] REVISION_RESET = 8'h00;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_ID  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVISION = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;  // write one entry of the initial image
    logic cfg_write;   // take a configuration write
    logic item_go;     // execute the accepted item
    logic load_out;    // capture the read byte into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last entry
  } status_t;

endpackage

/* sv/prf_ctrl.sv */
// Controller state machine of the paged register file.
module prf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       req_type,
  input  logic             out_stall,
  input  logic             cfg_valid,
  input  prf_pkg::status_t status,
  output prf_pkg::cmd_t    cmd,
  output logic             in_stall,
  output logic             out_valid
);
  import prf_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next     = state;
    cmd.clear_step = 1'b0;
    cmd.cfg_write  = cfg_valid;
    cmd.item_go    = 1'b0;
    cmd.load_out   = 1'b0;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    case (state)
      ST_CLEAR: begin
        // A configuration write takes the memory port for its cycle.
        cmd.clear_step = !cfg_valid;
        if (!cfg_valid && status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall    = cfg_valid;
        cmd.item_go = in_valid && !cfg_valid;
        if (cmd.item_go && (req_type == REQ_READ_BYTE)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.load_out = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/prf_datapath.sv */
// Datapath of the paged register file: store, pointer, page and output register.
module prf_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  prf_pkg::cmd_t                    cmd,
  output prf_pkg::status_t                 status,
  input  logic [1:0]                       req_type,
  input  logic [prf_pkg::DATA_W-1:0]       data_byte,
  input  logic [prf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prf_pkg::DATA_W-1:0]       cfg_data,
  output logic [prf_pkg::DATA_W-1:0]       read_data
);
  import prf_pkg::*;

  logic [DATA_W-1:0] store [STORE_DEPTH];

  logic [ADDR_W-1:0] clear_addr;
  logic [DATA_W-1:0] chip_id;
  logic [DATA_W-1:0] revision;
  logic [PAGE_W-1:0] page;
  logic [REG_W-1:0]  pointer;
  logic              loaded;
  logic              page_hit;
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] read_data_reg;

  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_we;
  logic [DATA_W-1:0] clear_value;
  logic              at_page_reg;

  localparam logic [ADDR_W-1:0] CHIP_ID_ADDR  = {{PAGE_W{1'b0}}, CHIP_ID_REG};
  localparam logic [ADDR_W-1:0] REVISION_ADDR = {{PAGE_W{1'b0}}, REVISION_REG};

  assign at_page_reg       = (pointer == PAGE_REG);
  assign status.clear_last = (clear_addr == ADDR_W'(STORE_DEPTH - 1));
  assign read_data         = read_data_reg;

  always_comb begin
    if (clear_addr == CHIP_ID_ADDR) begin
      clear_value = chip_id;
    end else if (clear_addr == REVISION_ADDR) begin
      clear_value = revision;
    end else begin
      clear_value = '0;
    end
  end

  // One memory port, shared by configuration, the clearing pass and items.
  always_comb begin
    mem_addr  = {page, pointer};
    mem_wdata = data_byte;
    mem_we    = 1'b0;
    if (cmd.cfg_write) begin
      mem_wdata = cfg_data;
      if (cfg_index == CFG_CHIP_ID) begin
        mem_addr = CHIP_ID_ADDR;
        mem_we   = 1'b1;
      end else if (cfg_index == CFG_REVISION) begin
        mem_addr = REVISION_ADDR;
        mem_we   = 1'b1;
      end
    end else if (cmd.clear_step) begin
      mem_addr  = clear_addr;
      mem_wdata = clear_value;
      mem_we    = 1'b1;
    end else if (cmd.item_go && (req_type == REQ_WRITE_BYTE) && loaded && !at_page_reg) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    mem_rdata <= store[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      chip_id    <= CHIP_ID_RESET;
      revision   <= REVISION_RESET;
      page       <= '0;
      pointer    <= '0;
      loaded     <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (cmd.cfg_write) begin
        if (cfg_index == CFG_CHIP_ID) begin
          chip_id <= cfg_data;
        end else if (cfg_index == CFG_REVISION) begin
          revision <= cfg_data;
        end
      end
      if (cmd.item_go) begin
        case (req_type)
          REQ_WRITE_START: begin
            loaded <= 1'b0;
          end
          REQ_WRITE_BYTE: begin
            if (!loaded) begin
              pointer <= data_byte;
              loaded  <= 1'b1;
            end else begin
              if (at_page_reg) begin
                page <= data_byte[PAGE_W-1:0];
              end
              pointer <= pointer + 1'b1;
            end
          end
          REQ_READ_BYTE: begin
            pointer <= pointer + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The page register reads back the current page instead of the store.
  always_ff @(posedge clk) begin
    if (cmd.item_go) begin
      page_hit <= at_page_reg;
    end
    if (cmd.load_out) begin
      read_data_reg <= page_hit ? DATA_W'(page) : mem_rdata;
    end
  end

endmodule

/* sv/paged_i2c_register_file.sv */
// A read request gives its byte from the output register; other items take effect when accepted.
// Throughput: one item per cycle for writes and bus events, barring configuration writes; a read
// holds later items until its byte is taken (single registered memory port, then output register).
// Reset: synchronous; a clearing pass then writes all 2048 store entries, one per cycle
// unless a configuration write takes the port, loading chip ID and revision at page 0 0xf4/0xf5;
// no item is accepted until the pass ends. Configuration writes are always taken, during it as well.
module paged_i2c_register_file (
  input  logic                             clk,
  input  logic                             rst,
  // Item input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       req_type,
  input  logic [prf_pkg::DATA_W-1:0]       data_byte,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [prf_pkg::DATA_W-1:0]       read_data,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prf_pkg::DATA_W-1:0]       cfg_data
);
  import prf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are taken in the cycle they are offered; they win the memory port
  // over the clearing pass and over items, which are held off meanwhile.
  assign cfg_ready = 1'b1;

  // The controller sequences the clearing pass, item execution and the
  // read handshake.
  prf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // The datapath holds the register store, the pointer, the page and the
  // result register.
  prf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_type  (req_type),
    .data_byte (data_byte),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .read_data (read_data)
  );

endmodule

/* tb/sv/paged_i2c_register_file_tb.sv */
// Self-checking testbench for the paged I2C register file, with a scoreboard that mirrors the store.
`timescale 1ns / 100ps

module paged_i2c_register_file_tb;
  import prf_pkg::*;

  // Cycles to let pass after the last read byte before a configuration write or the end,
  // so that a trailing write item has surely left the pipeline.
  localparam int SETTLE = 6;
  // Covers the clearing pass and all item traffic, taken many times over.
  localparam int unsigned MAX_CYCLES = 200_000;

  // Mirror of the register side: store, page, pointer, and the read bytes still due.
  class page_store_sb;
    logic [DATA_W-1:0] regs [STORE_DEPTH];
    logic [PAGE_W-1:0] page;
    logic [REG_W-1:0]  ptr;
    bit                ptr_loaded;
    logic [DATA_W-1:0] reads_due [$];
    int                errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[{PAGE_W'(0), CHIP_ID_REG}]  = CHIP_ID_RESET;
      regs[{PAGE_W'(0), REVISION_REG}] = REVISION_RESET;
      page       = '0;
      ptr        = '0;
      ptr_loaded = 1'b0;
      errors     = 0;
    endfunction

    // A configuration write lands in its page 0 entry at once.
    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        CFG_CHIP_ID:  regs[{PAGE_W'(0), CHIP_ID_REG}]  = val;
        CFG_REVISION: regs[{PAGE_W'(0), REVISION_REG}] = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] req, logic [DATA_W-1:0] data);
      case (req)
        REQ_WRITE_START: ptr_loaded = 1'b0;
        REQ_WRITE_BYTE: begin
          if (!ptr_loaded) begin
            ptr        = data;
            ptr_loaded = 1'b1;
          end else begin
            // The page register is shared by all pages and never touches the store.
            if (ptr == PAGE_REG) begin
              page = data[PAGE_W-1:0];
            end else begin
              regs[{page, ptr}] = data;
            end
            ptr = ptr + 1'b1;
          end
        end
        REQ_READ_BYTE: begin
          reads_due.push_back((ptr == PAGE_REG) ? DATA_W'(page) : regs[{page, ptr}]);
          ptr = ptr + 1'b1;
        end
        default: ;  // Start of read leaves the pointer where it was.
      endcase
    endfunction

    function void check_read(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (reads_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: read_data %02h with no read pending", $time, got);
        return;
      end
      want = reads_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: read_data mismatch, expected %02h, got %02h", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return reads_due.size();
    endfunction

    function void check_leftover();
      if (reads_due.size() != 0) begin
        $display("%0d read bytes never returned", reads_due.size());
        errors += reads_due.size();
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [1:0]             req_type  = REQ_WRITE_START;
  logic [DATA_W-1:0]      data_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DATA_W-1:0]      read_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_CHIP_ID;
  logic [DATA_W-1:0]      cfg_data  = '0;

  page_store_sb sb = new();
  bit           steady = 1'b0;  // no idling on either side while set
  int           sent   = 0;     // items that do something, start of read excluded
  int unsigned  cycles = 0;

  paged_i2c_register_file u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Everything that crosses a handshake is recorded at the rising edge where it happens.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_item(req_type, data_byte);
      if (out_valid && !out_stall) sb.check_read(read_data);
    end
  end

  // The receiver stalls at random with a chance of 29 in a hundred, except during the steady stretch.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one item and returns at the falling edge after it was taken. The valid stays
  // high so that a following item goes out back to back; idle gaps lower it.
  task automatic send(logic [1:0] req, logic [DATA_W-1:0] data);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    data_byte <= data;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (req != REQ_READ_START) sent++;
  endtask

  // The sender goes quiet until every read byte has come back.
  task automatic hold_off();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Loads new chip ID and revision values while the block is idle, then reads them back
  // through page 0.
  task automatic program_ids(logic [DATA_W-1:0] chip, logic [DATA_W-1:0] rev);
    hold_off();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CHIP_ID;
    cfg_data  <= chip;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_REVISION;
    cfg_data  <= rev;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send(REQ_WRITE_START, 8'h00);
    send(REQ_WRITE_BYTE, PAGE_REG);
    send(REQ_WRITE_BYTE, 8'h00);
    send(REQ_WRITE_START, 8'h00);
    send(REQ_WRITE_BYTE, CHIP_ID_REG);
    send(REQ_READ_BYTE, 8'h00);
    send(REQ_READ_BYTE, 8'h00);
  endtask

  // Register offsets lean toward the low end and the top of the page, where written
  // bytes get read back and the pointer wraps.
  function automatic logic [REG_W-1:0] pick_reg();
    case ($urandom_range(3))
      0:       return REG_W'($urandom_range(7));
      1:       return REG_W'($urandom_range(255, 240));
      default: return REG_W'($urandom());
    endcase
  endfunction

  // Mostly well-formed bus transfers with random content, some page switches and some
  // noise, until the given number of items has gone out.
  task automatic run_traffic(int quota);
    int stop;
    int kind;
    int len;
    stop = sent + quota;
    while (sent < stop) begin
      kind = $urandom_range(99);
      len  = $urandom_range(6, 1);
      if (kind < 35) begin
        send(REQ_WRITE_START, 8'($urandom()));
        send(REQ_WRITE_BYTE, pick_reg());
        repeat (len) send(REQ_WRITE_BYTE, 8'($urandom()));
      end else if (kind < 70) begin
        if ($urandom_range(9) < 7) begin
          send(REQ_WRITE_START, 8'($urandom()));
          send(REQ_WRITE_BYTE, pick_reg());
        end
        send(REQ_READ_START, 8'($urandom()));
        repeat (len) send(REQ_READ_BYTE, 8'($urandom()));
      end else if (kind < 85) begin
        send(REQ_WRITE_START, 8'($urandom()));
        send(REQ_WRITE_BYTE, PAGE_REG);
        send(REQ_WRITE_BYTE, 8'($urandom()));
      end else begin
        repeat ($urandom_range(3, 1)) send(2'($urandom_range(3)), 8'($urandom()));
      end
      if ($urandom_range(29) == 0) hold_off();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A written byte with no start of write before it still loads the pointer. The block
    // takes nothing until its clearing pass is over, so this also waits that out.
    send(REQ_WRITE_BYTE, CHIP_ID_REG);
    send(REQ_READ_BYTE, 8'h00);
    // Start of read keeps the pointer, so reading goes on at the revision register.
    send(REQ_READ_START, 8'h00);
    send(REQ_READ_BYTE, 8'h00);
    send(REQ_READ_BYTE, 8'h00);
    // Write across the page register: the pointer wraps and the later bytes go to page 5.
    send(REQ_WRITE_START, 8'h00);
    send(REQ_WRITE_BYTE, 8'hFE);
    send(REQ_WRITE_BYTE, 8'h5A);
    send(REQ_WRITE_BYTE, 8'hFD);
    send(REQ_WRITE_BYTE, 8'hA5);
    send(REQ_WRITE_BYTE, 8'h3C);
    // Reading the page register returns the page, and reading on past it wraps to zero.
    send(REQ_WRITE_START, 8'hFF);
    send(REQ_WRITE_BYTE, PAGE_REG);
    send(REQ_READ_BYTE, 8'hFF);
    send(REQ_READ_BYTE, 8'h00);
    send(REQ_READ_BYTE, 8'h00);
    // Only the low bits of the page byte count; then an all-ones byte at page 0 offset 0.
    send(REQ_WRITE_START, 8'h00);
    send(REQ_WRITE_BYTE, PAGE_REG);
    send(REQ_WRITE_BYTE, 8'hF8);
    send(REQ_WRITE_BYTE, 8'hFF);
    send(REQ_WRITE_START, 8'h00);
    send(REQ_WRITE_BYTE, 8'hFE);
    send(REQ_READ_BYTE, 8'h00);
    send(REQ_READ_BYTE, 8'h00);
    send(REQ_READ_BYTE, 8'h00);

    program_ids(8'hFF, 8'hFF);
    run_traffic(125);
    program_ids(8'($urandom()), 8'($urandom()));
    steady = 1'b1;
    run_traffic(125);
    steady = 1'b0;
    program_ids(8'h00, 8'h00);
    run_traffic(125);
    program_ids(8'($urandom()), 8'($urandom()));
    run_traffic(125);

    hold_off();
    repeat (SETTLE) @(negedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
